// File: rtl/job_queue_with_cancel_dispatch_macros.svh
// assertion macros used by the job queue rtl
`ifndef JOB_QUEUE_WITH_CANCEL_DISPATCH_MACROS_SVH
`define JOB_QUEUE_WITH_CANCEL_DISPATCH_MACROS_SVH

// same-cycle implication
`define JQCD_ASSERT_IMPL(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("jqcd: implication check failed");

// next-cycle implication
`define JQCD_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("jqcd: next-cycle check failed");

// condition that must never hold
`define JQCD_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("jqcd: forbidden condition seen");

`endif

// File: rtl/jqcd_pkg.sv
// types and constants of the job queue
package jqcd_pkg;

	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned ID_W        = 32;
	localparam int unsigned PAY_W       = 32;
	localparam int unsigned ENTRY_W     = ID_W + PAY_W;
	localparam int unsigned LIMIT_W     = 8;
	localparam int unsigned NRES_W      = 5;

	typedef enum logic [1:0] {
		REQ_SUBMIT      = 2'd0,
		REQ_WORKER_IDLE = 2'd1,
		REQ_CANCEL      = 2'd2,
		REQ_SHUTDOWN    = 2'd3
	} req_type_t;

	typedef enum logic [2:0] {
		STAT_SUBMITTED   = 3'd0,
		STAT_FULL        = 3'd1,
		STAT_TERMINATED  = 3'd2,
		STAT_REMOVED     = 3'd3,
		STAT_NOT_FOUND   = 3'd4,
		STAT_DISPATCHED  = 3'd5,
		STAT_FLUSHED     = 3'd6,
		STAT_TERMINATING = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REPLY,
		ST_DISP_RD,
		ST_DISP_EMIT,
		ST_SRCH,
		ST_SHIFT,
		ST_FLUSH_RD,
		ST_FLUSH_EMIT
	} ctrl_state_t;

	typedef struct packed {
		status_t            status;
		logic [ID_W-1:0]    job_id;
		logic [PAY_W-1:0]   payload;
		logic               last;
	} res_item_t;

endpackage

// File: rtl/jqcd_store.sv
// job store: one write port, one registered read port
module jqcd_store #(
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [AW-1:0]                    wr_addr,
	input  logic [jqcd_pkg::ENTRY_W-1:0]     wr_data,
	input  logic                             rd_en,
	input  logic [AW-1:0]                    rd_addr,
	output logic [jqcd_pkg::ENTRY_W-1:0]     rd_data
);

	logic [jqcd_pkg::ENTRY_W-1:0] mem [DEPTH];
	logic [jqcd_pkg::ENTRY_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/jqcd_ctrl.sv
// queue sequencer: request decode, cancel search and compaction, dispatch and flush
`include "job_queue_with_cancel_dispatch_macros.svh"

module jqcd_ctrl #(
	parameter int unsigned QUEUE_DEPTH = 16,
	localparam int unsigned IW = $clog2(QUEUE_DEPTH),
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       req_type,
	input  logic [jqcd_pkg::PAY_W-1:0]       payload,
	input  logic [jqcd_pkg::ID_W-1:0]        job_id,
	input  logic                             cfg_wr_en,
	input  logic [jqcd_pkg::LIMIT_W-1:0]     cfg_wr_data,
	output logic                             res_push,
	output jqcd_pkg::res_item_t              res_item,
	input  logic                             res_free,
	output logic                             wr_en,
	output logic [IW-1:0]                    wr_addr,
	output logic [jqcd_pkg::ENTRY_W-1:0]     wr_data,
	output logic                             rd_en,
	output logic [IW-1:0]                    rd_addr,
	input  logic [jqcd_pkg::ENTRY_W-1:0]     rd_data
);

	localparam int unsigned LW = jqcd_pkg::LIMIT_W;
	localparam int unsigned NW = jqcd_pkg::NRES_W;

	jqcd_pkg::ctrl_state_t state_q, state_d;

	logic [IW-1:0]                  head_q, head_d;
	logic [CW-1:0]                  count_q, count_d;
	logic [jqcd_pkg::ID_W-1:0]      next_id_q, next_id_d;
	logic [LW-1:0]                  busy_q, busy_d;
	logic [LW-1:0]                  wait_q, wait_d;
	logic                           shut_q, shut_d;
	logic [LW-1:0]                  max_q;
	logic [CW-1:0]                  ptr_q, ptr_d;
	logic                           rd_valid_s1, rd_valid_d;
	logic [CW-1:0]                  idx_s1, idx_d;
	logic [NW-1:0]                  n_q, n_d;

	logic [jqcd_pkg::ID_W-1:0]      id_q, id_d;
	jqcd_pkg::status_t              res_status_q, res_status_d;
	logic [jqcd_pkg::ID_W-1:0]      res_id_q, res_id_d;
	logic                           res_final_q, res_final_d;

	logic accept;
	logic work_ok;
	logic disp_ok;
	logic item_last;

	// ring slot of an offset from the head
	function automatic logic [IW-1:0] slot(input logic [IW-1:0] hd, input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(hd) + (CW+1)'(off);
		if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW+1)'(QUEUE_DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	assign in_ready = (state_q == jqcd_pkg::ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign work_ok  = (wait_q != '0) && (count_q != '0) && (busy_q < max_q);
	assign disp_ok  = work_ok && (n_q < NW'(jqcd_pkg::MAX_RESULTS));

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		count_d      = count_q;
		next_id_d    = next_id_q;
		busy_d       = busy_q;
		wait_d       = wait_q;
		shut_d       = shut_q;
		ptr_d        = ptr_q;
		rd_valid_d   = rd_valid_s1;
		idx_d        = idx_s1;
		n_d          = n_q;
		id_d         = id_q;
		res_status_d = res_status_q;
		res_id_d     = res_id_q;
		res_final_d  = res_final_q;
		wr_en        = 1'b0;
		wr_addr      = '0;
		wr_data      = '0;
		rd_en        = 1'b0;
		rd_addr      = '0;
		res_push     = 1'b0;
		res_item     = '0;
		item_last    = 1'b0;

		unique case (state_q)
			jqcd_pkg::ST_IDLE: begin
				if (accept) begin
					n_d = '0;
					if (shut_q) begin
						res_status_d = (jqcd_pkg::req_type_t'(req_type) == jqcd_pkg::REQ_SHUTDOWN)
							? jqcd_pkg::STAT_TERMINATING : jqcd_pkg::STAT_TERMINATED;
						res_id_d     = '0;
						res_final_d  = 1'b1;
						state_d      = jqcd_pkg::ST_REPLY;
					end else begin
						unique case (jqcd_pkg::req_type_t'(req_type))
							jqcd_pkg::REQ_SUBMIT: begin
								res_final_d = 1'b0;
								state_d     = jqcd_pkg::ST_REPLY;
								if (count_q == CW'(QUEUE_DEPTH)) begin
									res_status_d = jqcd_pkg::STAT_FULL;
									res_id_d     = '0;
								end else begin
									wr_en        = 1'b1;
									wr_addr      = slot(head_q, count_q);
									wr_data      = {next_id_q, payload};
									count_d      = count_q + 1'b1;
									res_status_d = jqcd_pkg::STAT_SUBMITTED;
									res_id_d     = next_id_q;
									next_id_d    = next_id_q + 1'b1;
								end
							end
							jqcd_pkg::REQ_WORKER_IDLE: begin
								if (busy_q != '0) begin
									busy_d = busy_q - 1'b1;
								end
								if (wait_q != '1) begin
									wait_d = wait_q + 1'b1;
								end
								state_d = jqcd_pkg::ST_DISP_RD;
							end
							jqcd_pkg::REQ_CANCEL: begin
								id_d       = job_id;
								ptr_d      = '0;
								rd_valid_d = 1'b0;
								state_d    = jqcd_pkg::ST_SRCH;
							end
							jqcd_pkg::REQ_SHUTDOWN: begin
								shut_d = 1'b1;
								if (count_q == '0) begin
									head_d       = '0;
									res_status_d = jqcd_pkg::STAT_TERMINATED;
									res_id_d     = '0;
									res_final_d  = 1'b1;
									state_d      = jqcd_pkg::ST_REPLY;
								end else begin
									ptr_d   = '0;
									state_d = jqcd_pkg::ST_FLUSH_RD;
								end
							end
							default: begin
								state_d = jqcd_pkg::ST_IDLE;
							end
						endcase
					end
				end
			end

			jqcd_pkg::ST_REPLY: begin
				// first dispatch always fits behind one reply
				item_last        = res_final_q | ~work_ok;
				res_push         = 1'b1;
				res_item.status  = res_status_q;
				res_item.job_id  = res_id_q;
				res_item.payload = '0;
				res_item.last    = item_last;
				if (res_free) begin
					n_d     = NW'(1);
					state_d = item_last ? jqcd_pkg::ST_IDLE : jqcd_pkg::ST_DISP_RD;
				end
			end

			jqcd_pkg::ST_DISP_RD: begin
				if (disp_ok) begin
					rd_en   = 1'b1;
					rd_addr = head_q;
					state_d = jqcd_pkg::ST_DISP_EMIT;
				end else begin
					state_d = jqcd_pkg::ST_IDLE;
				end
			end

			jqcd_pkg::ST_DISP_EMIT: begin
				item_last = ~((n_q + 1'b1 < NW'(jqcd_pkg::MAX_RESULTS))
					&& (wait_q != LW'(1)) && (count_q != CW'(1))
					&& (busy_q + 1'b1 < max_q));
				res_push         = 1'b1;
				res_item.status  = jqcd_pkg::STAT_DISPATCHED;
				res_item.job_id  = rd_data[jqcd_pkg::ENTRY_W-1:jqcd_pkg::PAY_W];
				res_item.payload = rd_data[jqcd_pkg::PAY_W-1:0];
				res_item.last    = item_last;
				if (res_free) begin
					head_d  = (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
					count_d = count_q - 1'b1;
					wait_d  = wait_q - 1'b1;
					busy_d  = busy_q + 1'b1;
					n_d     = n_q + 1'b1;
					state_d = item_last ? jqcd_pkg::ST_IDLE : jqcd_pkg::ST_DISP_RD;
				end
			end

			jqcd_pkg::ST_SRCH: begin
				// one read issued per cycle, compared in the following cycle
				if (rd_valid_s1 && (rd_data[jqcd_pkg::ENTRY_W-1:jqcd_pkg::PAY_W] == id_q)) begin
					ptr_d      = idx_s1 + 1'b1;
					rd_valid_d = 1'b0;
					state_d    = jqcd_pkg::ST_SHIFT;
				end else if (ptr_q < count_q) begin
					rd_en      = 1'b1;
					rd_addr    = slot(head_q, ptr_q);
					rd_valid_d = 1'b1;
					idx_d      = ptr_q;
					ptr_d      = ptr_q + 1'b1;
				end else begin
					rd_valid_d = 1'b0;
					if (!rd_valid_s1) begin
						res_status_d = jqcd_pkg::STAT_NOT_FOUND;
						res_id_d     = id_q;
						res_final_d  = 1'b0;
						state_d      = jqcd_pkg::ST_REPLY;
					end
				end
			end

			jqcd_pkg::ST_SHIFT: begin
				// write entry j from the read of j+1, next read already two ahead
				if (rd_valid_s1) begin
					wr_en   = 1'b1;
					wr_addr = slot(head_q, idx_s1);
					wr_data = rd_data;
				end
				if (ptr_q < count_q) begin
					rd_en      = 1'b1;
					rd_addr    = slot(head_q, ptr_q);
					rd_valid_d = 1'b1;
					idx_d      = ptr_q - 1'b1;
					ptr_d      = ptr_q + 1'b1;
				end else begin
					rd_valid_d = 1'b0;
					if (!rd_valid_s1) begin
						count_d      = count_q - 1'b1;
						res_status_d = jqcd_pkg::STAT_REMOVED;
						res_id_d     = id_q;
						res_final_d  = 1'b0;
						state_d      = jqcd_pkg::ST_REPLY;
					end
				end
			end

			jqcd_pkg::ST_FLUSH_RD: begin
				rd_en   = 1'b1;
				rd_addr = slot(head_q, ptr_q);
				state_d = jqcd_pkg::ST_FLUSH_EMIT;
			end

			jqcd_pkg::ST_FLUSH_EMIT: begin
				item_last = (ptr_q + 1'b1 == count_q)
					|| (n_q + 1'b1 == NW'(jqcd_pkg::MAX_RESULTS));
				res_push         = 1'b1;
				res_item.status  = jqcd_pkg::STAT_FLUSHED;
				res_item.job_id  = rd_data[jqcd_pkg::ENTRY_W-1:jqcd_pkg::PAY_W];
				res_item.payload = rd_data[jqcd_pkg::PAY_W-1:0];
				res_item.last    = item_last;
				if (res_free) begin
					n_d   = n_q + 1'b1;
					ptr_d = ptr_q + 1'b1;
					if (item_last) begin
						head_d  = '0;
						count_d = '0;
						state_d = jqcd_pkg::ST_IDLE;
					end else begin
						state_d = jqcd_pkg::ST_FLUSH_RD;
					end
				end
			end

			default: begin
				state_d = jqcd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= jqcd_pkg::ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			next_id_q   <= jqcd_pkg::ID_W'(1);
			busy_q      <= '0;
			wait_q      <= '0;
			shut_q      <= 1'b0;
			ptr_q       <= '0;
			rd_valid_s1 <= 1'b0;
			n_q         <= '0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			count_q     <= count_d;
			next_id_q   <= next_id_d;
			busy_q      <= busy_d;
			wait_q      <= wait_d;
			shut_q      <= shut_d;
			ptr_q       <= ptr_d;
			rd_valid_s1 <= rd_valid_d;
			n_q         <= n_d;
		end
	end

	// concurrency limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= LW'(1);
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1       <= idx_d;
		id_q         <= id_d;
		res_status_q <= res_status_d;
		res_id_q     <= res_id_d;
		res_final_q  <= res_final_d;
	end

	`JQCD_ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CW'(QUEUE_DEPTH))
	`JQCD_ASSERT_NEXT(a_shut_sticky, clk, arst_n, shut_q, shut_q)
	`JQCD_ASSERT_IMPL(a_disp_has_work, clk, arst_n, res_push && (res_item.status == jqcd_pkg::STAT_DISPATCHED), (wait_q != '0) && (count_q != '0))
	`JQCD_ASSERT_IMPL(a_result_cap, clk, arst_n, res_push, n_q < NW'(jqcd_pkg::MAX_RESULTS))
	`JQCD_ASSERT_NEVER(a_rw_same_slot, clk, arst_n, wr_en && rd_en && (wr_addr == rd_addr))

endmodule

// File: rtl/job_queue_with_cancel_dispatch.sv
// top level of the ring job queue with cancel and dispatch
//
// usage
// - input channel (in_valid/in_ready) takes one request item: req_type selects
//   submit, worker idle, cancel by job_id or shutdown; payload goes with submit
// - output channel (out_valid/out_ready) gives result items, last marks the final
//   result of a request; a worker-idle request that dispatches nothing gives none
// - cfg_wr_en/cfg_wr_data write max_running, the limit on jobs running at once
// steps per item
// - submit or reply-only request: accepted in idle, then the reply is registered
// - each dispatch or flush result: a store read, then the result
// - cancel: search and compaction stream one store entry per cycle through the
//   single read port, then the reply
// - in_ready is high only while the sequencer is idle, one item at a time
// reset clears the queue, job numbers restart at 1, max_running returns to 1;
// the store contents are not cleared, no entry is read before it is written
// a stalled receiver holds the output register; the sequencer waits on it and
// resumes without loss, and a new item may be taken while the last result waits
module job_queue_with_cancel_dispatch #(
	parameter int unsigned QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] payload,
	input  logic [31:0] job_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] result_job_id,
	output logic [31:0] result_payload,
	output logic        last,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	localparam int unsigned IW = $clog2(QUEUE_DEPTH);

	logic                          res_push;
	logic                          res_free;
	jqcd_pkg::res_item_t           res_item;

	// store port wires
	logic                          st_wr_en;
	logic [IW-1:0]                 st_wr_addr;
	logic [jqcd_pkg::ENTRY_W-1:0]  st_wr_data;
	logic                          st_rd_en;
	logic [IW-1:0]                 st_rd_addr;
	logic [jqcd_pkg::ENTRY_W-1:0]  st_rd_data;

	// output register
	logic                          out_valid_q;
	jqcd_pkg::res_item_t           out_item_q;

	assign res_free = ~out_valid_q | out_ready;

	jqcd_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.payload     (payload),
		.job_id      (job_id),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.res_push    (res_push),
		.res_item    (res_item),
		.res_free    (res_free),
		.wr_en       (st_wr_en),
		.wr_addr     (st_wr_addr),
		.wr_data     (st_wr_data),
		.rd_en       (st_rd_en),
		.rd_addr     (st_rd_addr),
		.rd_data     (st_rd_data)
	);

	jqcd_store #(
		.DEPTH (QUEUE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_en   (st_rd_en),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data)
	);

	// result is loaded whenever the register is empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push && res_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push && res_free) begin
			out_item_q <= res_item;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_item_q.status;
	assign result_job_id  = out_item_q.job_id;
	assign result_payload = out_item_q.payload;
	assign last           = out_item_q.last;

endmodule
